/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the game clock.
// Both macros sample on clk and stand down while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define GCLK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A stalled valid keeps its signal unchanged.
`define GCLK_ASSERT_HOLD(label, vld, rdy, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		vld && !rdy |=> vld && $stable(sig)) else $error(msg);

`endif

/* rtl/core/gclk_pkg.sv */
// Types, codes and constants of the two-player game clock.
// Used by every design module of the block; depends on nothing.
package gclk_pkg;

	localparam int TIME_W   = 32;
	localparam int INC_W    = 22;
	localparam int CFG_IDX_W = 2;

	localparam logic [TIME_W-1:0] START_MS_RST = 32'd300000;
	localparam logic [INC_W-1:0]  INC_MS_RST   = 22'd0;

	// Item queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Reciprocals for exact division by constants (floor(x * R >> k))
	localparam logic [30:0] RECIP_100 = 31'd1374389535; // k = 37, x < 2^32
	localparam logic [25:0] RECIP_10  = 26'd53687092;   // k = 29, x < 2^26
	localparam logic [22:0] RECIP_60S = 23'd4473925;    // k = 28, x < 6100859
	localparam logic [16:0] RECIP_60M = 17'd69906;      // k = 22, x < 74898
	localparam logic [7:0]  RECIP_5   = 8'd205;         // k = 10, x < 1024

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		SIDE_WHITE = 2'd0,
		SIDE_BLACK = 2'd1,
		SIDE_NONE  = 2'd2
	} side_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHITE_START = 2'd0,
		REG_BLACK_START = 2'd1,
		REG_INCREMENT   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		op_t   op;
		side_t side;
	} item_t;

	typedef struct packed {
		logic [10:0] hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [3:0]  tenths;
	} dig_t;

	// Sum of the eight nibbles; congruent to the word modulo 5 (16 = 1 mod 5)
	function automatic logic [6:0] nibble_sum(input logic [TIME_W-1:0] w);
		logic [6:0] acc;
		acc = '0;
		for (int i = 0; i < TIME_W / 4; i++) begin
			acc = acc + 7'(w[i*4 +: 4]);
		end
		return acc;
	endfunction

endpackage

/* rtl/core/gclk_front.sv */
// Front end of the game clock: accepts items, classifies them and queues them.
// Depends on gclk_pkg for the item type and queue depth.
module gclk_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [1:0]         turn,
	output logic               head_valid,
	output gclk_pkg::item_t    head,
	input  logic               pop
);

	gclk_pkg::item_t                 queue_q [gclk_pkg::QUEUE_DEPTH];
	logic [gclk_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [gclk_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [gclk_pkg::QCNT_W-1:0]     count_q;
	gclk_pkg::item_t                 cls;
	logic                            push;

	// Map the raw item to an op and a side; turn codes two and three count as none
	always_comb begin
		cls.op = cmd ? gclk_pkg::OP_START : gclk_pkg::OP_TICK;
		unique case (turn)
			2'd0:    cls.side = gclk_pkg::SIDE_WHITE;
			2'd1:    cls.side = gclk_pkg::SIDE_BLACK;
			default: cls.side = gclk_pkg::SIDE_NONE;
		endcase
	end

	assign in_ready   = (count_q != gclk_pkg::QCNT_W'(gclk_pkg::QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != '0);
	assign head       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + gclk_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gclk_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + gclk_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - gclk_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/core/gclk_split.sv */
// One lane of the time splitter: milliseconds to hours, minutes, seconds, tenths.
// Five stages, four of them reciprocal multiplies; depends on gclk_pkg for constants and types.
module gclk_split (
	input  logic                          clk,
	input  logic                          en,
	input  logic [gclk_pkg::TIME_W-1:0]   ms_in,
	output logic [gclk_pkg::TIME_W-1:0]   ms_out,
	output gclk_pkg::dig_t                dig
);

	logic [62:0] prod100;
	logic [51:0] prod10;
	logic [45:0] prod60s;
	logic [33:0] prod60m;
	logic [25:0] tenths_diff;
	logic [22:0] sec_diff;
	logic [16:0] min_diff;

	logic [gclk_pkg::TIME_W-1:0] ms_s2, ms_s3, ms_s4, ms_s5;
	logic [25:0] t_s2, t_s3;
	logic [22:0] s_s3, s_s4;
	logic [16:0] m_s4, m_s5;
	logic [3:0]  ten_s4, ten_s5;
	logic [10:0] h_s5;
	logic [5:0]  sec_s5;

	always_comb begin
		prod100     = 63'(ms_in) * 63'(gclk_pkg::RECIP_100);
		prod10      = 52'(t_s2) * 52'(gclk_pkg::RECIP_10);
		prod60s     = 46'(s_s3) * 46'(gclk_pkg::RECIP_60S);
		prod60m     = 34'(m_s4) * 34'(gclk_pkg::RECIP_60M);
		// remainders: x - 10q, x - 60q with 60q = 64q - 4q
		tenths_diff = t_s3 - 26'({s_s3, 3'b000}) - 26'({s_s3, 1'b0});
		sec_diff    = s_s4 - 23'({m_s4, 6'b000000}) + 23'({m_s4, 2'b00});
		min_diff    = m_s5 - 17'({h_s5, 6'b000000}) + 17'({h_s5, 2'b00});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// tenths count: ms / 100
			ms_s2 <= ms_in;
			t_s2  <= prod100[62:37];
			// whole seconds: tenths / 10
			ms_s3 <= ms_s2;
			t_s3  <= t_s2;
			s_s3  <= prod10[51:29];
			// whole minutes: seconds / 60
			ms_s4  <= ms_s3;
			s_s4   <= s_s3;
			m_s4   <= prod60s[44:28];
			ten_s4 <= tenths_diff[3:0];
			// hours: minutes / 60
			ms_s5  <= ms_s4;
			m_s5   <= m_s4;
			h_s5   <= prod60m[32:22];
			sec_s5 <= sec_diff[5:0];
			ten_s5 <= ten_s4;
			// output register
			ms_out      <= ms_s5;
			dig.hours   <= h_s5;
			dig.minutes <= min_diff[5:0];
			dig.seconds <= sec_s5;
			dig.tenths  <= ten_s5;
		end
	end

endmodule

/* rtl/core/gclk_back.sv */
// Back end of the game clock: configuration, clock state update and result pipeline.
// Depends on gclk_pkg and instantiates two gclk_split lanes.
module gclk_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gclk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gclk_pkg::TIME_W-1:0]     cfg_data,
	input  logic                            head_valid,
	input  gclk_pkg::item_t                 head,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [gclk_pkg::TIME_W-1:0]     white_ms,
	output logic [gclk_pkg::TIME_W-1:0]     black_ms,
	output logic                            running,
	output logic                            refresh,
	output gclk_pkg::dig_t                  white_dig,
	output gclk_pkg::dig_t                  black_dig
);

	logic [gclk_pkg::TIME_W-1:0] white_start_q, black_start_q;
	logic [gclk_pkg::INC_W-1:0]  inc_q;

	logic [gclk_pkg::TIME_W-1:0] white_q, black_q;
	logic                        counting_q;
	gclk_pkg::side_t             last_q;

	logic [gclk_pkg::TIME_W-1:0] nxt_white, nxt_black;
	logic                        nxt_counting;
	gclk_pkg::side_t             nxt_last;
	logic [gclk_pkg::TIME_W-1:0] dec_white, dec_black;
	logic [gclk_pkg::TIME_W-1:0] sat_white, sat_black;
	logic [gclk_pkg::TIME_W:0]   sum_white, sum_black;

	logic                        en;
	logic                        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [gclk_pkg::TIME_W-1:0] white_s1, black_s1;
	gclk_pkg::side_t             side_s1;
	logic                        run_s1, run_s2, run_s3, run_s4, run_s5, run_s6;
	logic [gclk_pkg::TIME_W-1:0] sel_ms;
	logic [6:0]                  nib_s2;
	logic                        even_s2, on_s2;
	logic [14:0]                 prod5;
	logic [6:0]                  q5x5;
	logic                        ref_s3, ref_s4, ref_s5, ref_s6;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_start_q <= gclk_pkg::START_MS_RST;
			black_start_q <= gclk_pkg::START_MS_RST;
			inc_q         <= gclk_pkg::INC_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gclk_pkg::REG_WHITE_START: white_start_q <= cfg_data;
				gclk_pkg::REG_BLACK_START: black_start_q <= cfg_data;
				gclk_pkg::REG_INCREMENT:   inc_q <= cfg_data[gclk_pkg::INC_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole result pipeline moves when the output register is free
	assign en  = !v_s6 || out_ready;
	assign pop = en && head_valid;

	always_comb begin
		dec_white = (white_q != '0) ? white_q - gclk_pkg::TIME_W'(1) : white_q;
		dec_black = (black_q != '0) ? black_q - gclk_pkg::TIME_W'(1) : black_q;
		sum_white = {1'b0, white_q} + (gclk_pkg::TIME_W + 1)'(inc_q);
		sum_black = {1'b0, black_q} + (gclk_pkg::TIME_W + 1)'(inc_q);
		// saturate at the top
		sat_white = sum_white[gclk_pkg::TIME_W] ? '1 : sum_white[gclk_pkg::TIME_W-1:0];
		sat_black = sum_black[gclk_pkg::TIME_W] ? '1 : sum_black[gclk_pkg::TIME_W-1:0];

		nxt_white    = white_q;
		nxt_black    = black_q;
		nxt_counting = counting_q;
		nxt_last     = last_q;
		if (head.op == gclk_pkg::OP_START) begin
			nxt_white    = white_start_q;
			nxt_black    = black_start_q;
			nxt_counting = 1'b1;
			nxt_last     = gclk_pkg::SIDE_WHITE;
		end else begin
			if (counting_q) begin
				unique case (head.side)
					gclk_pkg::SIDE_WHITE: begin
						nxt_white = dec_white;
						// black just moved: credit the increment
						if (last_q != gclk_pkg::SIDE_WHITE) begin
							nxt_black = sat_black;
						end
					end
					gclk_pkg::SIDE_BLACK: begin
						nxt_black = dec_black;
						if (last_q != gclk_pkg::SIDE_BLACK) begin
							nxt_white = sat_white;
						end
					end
					default: nxt_counting = 1'b0;
				endcase
				if (nxt_white == '0 || nxt_black == '0) begin
					nxt_counting = 1'b0;
				end
			end
			nxt_last = head.side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q    <= '0;
			black_q    <= '0;
			counting_q <= 1'b0;
			last_q     <= gclk_pkg::SIDE_WHITE;
		end else if (pop) begin
			white_q    <= nxt_white;
			black_q    <= nxt_black;
			counting_q <= nxt_counting;
			last_q     <= nxt_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Refresh: on-turn time divisible by 2 and by 5
	always_comb begin
		sel_ms = (side_s1 == gclk_pkg::SIDE_WHITE) ? white_s1 : black_s1;
		prod5  = 15'(nib_s2) * 15'(gclk_pkg::RECIP_5);
		q5x5   = 7'({prod5[14:10], 2'b00}) + 7'(prod5[14:10]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			white_s1 <= nxt_white;
			black_s1 <= nxt_black;
			run_s1   <= nxt_counting;
			side_s1  <= head.side;

			nib_s2  <= gclk_pkg::nibble_sum(sel_ms);
			even_s2 <= ~sel_ms[0];
			on_s2   <= (side_s1 == gclk_pkg::SIDE_WHITE) ||
			           (side_s1 == gclk_pkg::SIDE_BLACK);
			run_s2  <= run_s1;

			ref_s3 <= on_s2 && even_s2 && (nib_s2 == q5x5);
			run_s3 <= run_s2;

			ref_s4 <= ref_s3;
			run_s4 <= run_s3;
			ref_s5 <= ref_s4;
			run_s5 <= run_s4;
			ref_s6 <= ref_s5;
			run_s6 <= run_s5;
		end
	end

	gclk_split u_white_split (
		.clk    (clk),
		.en     (en),
		.ms_in  (white_s1),
		.ms_out (white_ms),
		.dig    (white_dig)
	);

	gclk_split u_black_split (
		.clk    (clk),
		.en     (en),
		.ms_in  (black_s1),
		.ms_out (black_ms),
		.dig    (black_dig)
	);

	assign out_valid = v_s6;
	assign running   = run_s6;
	assign refresh   = ref_s6;

endmodule

/* rtl/core/two_player_game_clock.sv */
// Top level of the two-player game clock with per-move increment.
// Depends on gclk_pkg, gclk_front and gclk_back.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | cmd, turn
//   out     | out_valid / out_ready| white_ms, black_ms, running, refresh, digits
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes the two-entry queue (leaving it updates the clock state), then the
// splitter's chain of reciprocal multiplies on its way to the result.
// A stall at the output freezes the result pipeline; the queue keeps taking items
// until it holds two. Reset empties the queue and pipeline and clears both times;
// configuration writes are always taken.
module two_player_game_clock (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            cmd,
	input  logic [1:0]                      turn,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [31:0]                     white_ms,
	output logic [31:0]                     black_ms,
	output logic                            running,
	output logic                            refresh,
	output logic [10:0]                     white_hours,
	output logic [5:0]                      white_minutes,
	output logic [5:0]                      white_seconds,
	output logic [3:0]                      white_tenths,
	output logic [10:0]                     black_hours,
	output logic [5:0]                      black_minutes,
	output logic [5:0]                      black_seconds,
	output logic [3:0]                      black_tenths,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gclk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);

	logic            head_valid;
	gclk_pkg::item_t head;
	logic            pop;
	gclk_pkg::dig_t  white_dig, black_dig;

	gclk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.turn       (turn),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	gclk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.white_ms   (white_ms),
		.black_ms   (black_ms),
		.running    (running),
		.refresh    (refresh),
		.white_dig  (white_dig),
		.black_dig  (black_dig)
	);

	assign white_hours   = white_dig.hours;
	assign white_minutes = white_dig.minutes;
	assign white_seconds = white_dig.seconds;
	assign white_tenths  = white_dig.tenths;
	assign black_hours   = black_dig.hours;
	assign black_minutes = black_dig.minutes;
	assign black_seconds = black_dig.seconds;
	assign black_tenths  = black_dig.tenths;

endmodule

/* rtl/core/gclk_checker.sv */
// Port-level checks of the game clock, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module gclk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] white_ms,
	input logic [31:0] black_ms,
	input logic [10:0] white_hours,
	input logic [5:0]  white_minutes,
	input logic [5:0]  white_seconds,
	input logic [3:0]  white_tenths,
	input logic [10:0] black_hours,
	input logic [5:0]  black_minutes,
	input logic [5:0]  black_seconds,
	input logic [3:0]  black_tenths
);

	`GCLK_ASSERT_HOLD(a_out_hold, out_valid, out_ready, white_ms, "stalled result changed")
	`GCLK_ASSERT(a_digit_range, out_valid |-> white_minutes <= 6'd59 && white_seconds <= 6'd59 && white_tenths <= 4'd9 && black_minutes <= 6'd59 && black_seconds <= 6'd59 && black_tenths <= 4'd9, "split digit out of range")
	`GCLK_ASSERT(a_white_zero, out_valid && white_ms == 32'd0 |-> white_hours == 11'd0 && white_minutes == 6'd0 && white_seconds == 6'd0 && white_tenths == 4'd0, "zero white time splits to nonzero digits")
	`GCLK_ASSERT(a_black_zero, out_valid && black_ms == 32'd0 |-> black_hours == 11'd0 && black_minutes == 6'd0 && black_seconds == 6'd0 && black_tenths == 4'd0, "zero black time splits to nonzero digits")

endmodule

bind two_player_game_clock gclk_checker u_gclk_checker (.*);
